// ===== sv/kls_pkg.sv =====
// Shared types, character codes, token kinds and the keyword list for the keyword lexer.
// Used by the scanner, the result buffer and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kls_pkg;

  // Token kinds
  localparam logic [4:0] KIND_LPAREN = 5'd21;
  localparam logic [4:0] KIND_RPAREN = 5'd22;
  localparam logic [4:0] KIND_COMMA  = 5'd23;
  localparam logic [4:0] KIND_DOT    = 5'd24;
  localparam logic [4:0] KIND_HASH   = 5'd25;
  localparam logic [4:0] KIND_STRING = 5'd26;
  localparam logic [4:0] KIND_NUMBER = 5'd27;
  localparam logic [4:0] KIND_IDENT  = 5'd28;
  localparam logic [4:0] KIND_EOF    = 5'd29;
  localparam logic [4:0] KIND_NONE   = 5'd0;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CHAR    = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  localparam int NUM_KEYWORDS = 21;

  // One result item
  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  error;
    logic [7:0]  bad_char;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] line_no;
    logic        last;
  } res_t;

  // All results caused by one source byte
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       item;
  } res_set_t;

  // Keyword spelling, right-aligned as a string literal (first character highest).
  function automatic logic [63:0] kw_raw(input int idx);
    logic [63:0] r;
    case (idx)
      0:       r = "plus";
      1:       r = "minus";
      2:       r = "into";
      3:       r = "div";
      4:       r = "reminder";
      5:       r = "greater";
      6:       r = "lesser";
      7:       r = "equal";
      8:       r = "not";
      9:       r = "and";
      10:      r = "or";
      11:      r = "when";
      12:      r = "then";
      13:      r = "nothing";
      14:      r = "with";
      15:      r = "from";
      16:      r = "to";
      17:      r = "var";
      18:      r = "is";
      19:      r = "read";
      20:      r = "say";
      default: r = '0;
    endcase
    return r;
  endfunction

  // Keyword length in characters.
  function automatic logic [3:0] kw_len(input int idx);
    logic [3:0] n;
    case (idx)
      0, 2, 11, 12, 14, 15, 19: n = 4'd4;
      1, 7:                     n = 4'd5;
      3, 8, 9, 17, 20:          n = 4'd3;
      4:                        n = 4'd8;
      5, 13:                    n = 4'd7;
      6:                        n = 4'd6;
      10, 16, 18:               n = 4'd2;
      default:                  n = 4'd0;
    endcase
    return n;
  endfunction

  // Keyword text with the first character in the lowest byte, zero padded.
  function automatic logic [63:0] kw_text(input int idx);
    logic [63:0] raw;
    logic [63:0] t;
    int          n;
    raw = kw_raw(idx);
    n   = int'(kw_len(idx));
    t   = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        t[i*8 +: 8] = raw[(n-1-i)*8 +: 8];
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kls_scan.sv =====
// Scanner state and per-byte token logic of the keyword lexer.
// Depends on kls_pkg; feeds a res_set_t to the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module kls_scan #(
  parameter longint unsigned SOURCE_LIMIT  = 65536,
  parameter int              KEYWORD_CHARS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [7:0]       symbol,
  input  wire logic             final_req,
  output kls_pkg::res_set_t     res_set
);

  localparam int KCB = KEYWORD_CHARS * 8;
  localparam int WLW = $clog2(KEYWORD_CHARS + 1);
  localparam logic [15:0] POS_MAX =
    ((SOURCE_LIMIT - 1) > 64'd65535) ? 16'hFFFF : 16'(SOURCE_LIMIT - 1);

  // Scanner modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_WORD   = 2'd2;
  localparam logic [1:0] MODE_STRING = 2'd3;

  logic [1:0]     mode_r, mode_nxt;
  logic [15:0]    pos_r, pos_nxt;
  logic [15:0]    ts_r, ts_nxt;
  logic [15:0]    line_r, line_nxt;
  logic [KCB-1:0] wbuf_r, wbuf_nxt;
  logic [WLW-1:0] wlen_r, wlen_nxt;
  logic           wlong_r, wlong_nxt;

  // Values after this byte, before end-of-source clearing
  logic [1:0]     mode_a;
  logic [15:0]    ts_a;
  logic [15:0]    line_a;
  logic [KCB-1:0] wbuf_a;
  logic [WLW-1:0] wlen_a;
  logic           wlong_a;

  logic           is_dig, is_alp, taken;
  logic [16:0]    end1;
  kls_pkg::res_t  cand [4];
  logic [3:0]     cv;
  logic [2:0]     n;

  function automatic logic [15:0] cap16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  // Distance from s to e, zero when e is not past s, saturated.
  function automatic logic [15:0] span(input logic [16:0] e, input logic [16:0] s);
    logic [16:0] d;
    d = (e > s) ? (e - s) : 17'd0;
    return cap16(d);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v != 16'hFFFF) ? (v + 16'd1) : v;
  endfunction

  // Keyword lookup; the buffer is zero beyond the word, so a full compare suffices.
  function automatic logic [4:0] word_kind(input logic [KCB-1:0] b, input logic [WLW-1:0] l,
                                           input logic lg);
    logic [4:0] k;
    k = kls_pkg::KIND_IDENT;
    if (!lg) begin
      for (int j = kls_pkg::NUM_KEYWORDS - 1; j >= 0; j--) begin
        if (b == KCB'(kls_pkg::kw_text(j)) && l == WLW'(kls_pkg::kw_len(j))) begin
          k = 5'(j);
        end
      end
    end
    return k;
  endfunction

  function automatic kls_pkg::res_t mk(input logic [4:0] kind, input logic [1:0] err,
                                       input logic [7:0] bad, input logic [15:0] off,
                                       input logic [15:0] len, input logic [15:0] ln);
    kls_pkg::res_t r;
    r.kind     = kind;
    r.error    = err;
    r.bad_char = bad;
    r.offset   = off;
    r.length   = len;
    r.line_no  = ln;
    r.last     = 1'b0;
    return r;
  endfunction

  // Per-byte token logic: pending token, the byte's own result, end-of-source results
  always_comb begin
    is_dig  = symbol inside {[8'h30:8'h39]};
    is_alp  = symbol inside {[8'h61:8'h7A], [8'h41:8'h5A], kls_pkg::CH_UNDER};
    end1    = {1'b0, pos_r} + 17'd1;
    taken   = 1'b0;
    mode_a  = mode_r;
    ts_a    = ts_r;
    line_a  = line_r;
    wbuf_a  = wbuf_r;
    wlen_a  = wlen_r;
    wlong_a = wlong_r;
    cv      = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    // Continue or close the token in progress
    case (mode_r)
      MODE_STRING: begin
        taken = 1'b1;
        if (symbol == kls_pkg::CH_QUOTE) begin
          cand[0] = mk(kls_pkg::KIND_STRING, kls_pkg::ERR_NONE, 8'd0,
                       cap16({1'b0, ts_r} + 17'd1),
                       span({1'b0, pos_r}, {1'b0, ts_r} + 17'd1), line_r);
          cv[0]   = 1'b1;
          mode_a  = MODE_IDLE;
        end else if (symbol == kls_pkg::CH_NL) begin
          line_a = sat_inc(line_r);
        end
      end
      MODE_NUMBER: begin
        if (is_dig) begin
          taken = 1'b1;
        end else begin
          cand[0] = mk(kls_pkg::KIND_NUMBER, kls_pkg::ERR_NONE, 8'd0, ts_r,
                       span({1'b0, pos_r}, {1'b0, ts_r}), line_r);
          cv[0]   = 1'b1;
          mode_a  = MODE_IDLE;
        end
      end
      MODE_WORD: begin
        if (is_dig || is_alp) begin
          taken = 1'b1;
          if (wlen_r < WLW'(KEYWORD_CHARS)) begin
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
              if (wlen_r == WLW'(i)) begin
                wbuf_a[i*8 +: 8] = symbol;
              end
            end
            wlen_a = wlen_r + WLW'(1);
          end else begin
            wlong_a = 1'b1;
          end
        end else begin
          cand[0] = mk(word_kind(wbuf_r, wlen_r, wlong_r), kls_pkg::ERR_NONE, 8'd0, ts_r,
                       span({1'b0, pos_r}, {1'b0, ts_r}), line_r);
          cv[0]   = 1'b1;
          mode_a  = MODE_IDLE;
        end
      end
      default: begin
      end
    endcase

    // The byte starts something of its own
    if (!taken) begin
      ts_a = pos_r;
      case (symbol)
        kls_pkg::CH_LPAREN: begin
          cand[1] = mk(kls_pkg::KIND_LPAREN, kls_pkg::ERR_NONE, 8'd0, pos_r, 16'd1, line_r);
          cv[1]   = 1'b1;
        end
        kls_pkg::CH_RPAREN: begin
          cand[1] = mk(kls_pkg::KIND_RPAREN, kls_pkg::ERR_NONE, 8'd0, pos_r, 16'd1, line_r);
          cv[1]   = 1'b1;
        end
        kls_pkg::CH_COMMA: begin
          cand[1] = mk(kls_pkg::KIND_COMMA, kls_pkg::ERR_NONE, 8'd0, pos_r, 16'd1, line_r);
          cv[1]   = 1'b1;
        end
        kls_pkg::CH_DOT: begin
          cand[1] = mk(kls_pkg::KIND_DOT, kls_pkg::ERR_NONE, 8'd0, pos_r, 16'd1, line_r);
          cv[1]   = 1'b1;
        end
        kls_pkg::CH_HASH: begin
          cand[1] = mk(kls_pkg::KIND_HASH, kls_pkg::ERR_NONE, 8'd0, pos_r, 16'd1, line_r);
          cv[1]   = 1'b1;
        end
        kls_pkg::CH_QUOTE: begin
          mode_a = MODE_STRING;
        end
        kls_pkg::CH_SPACE, kls_pkg::CH_CR, kls_pkg::CH_TAB: begin
        end
        kls_pkg::CH_NL: begin
          line_a = sat_inc(line_r);
        end
        default: begin
          if (is_dig) begin
            mode_a = MODE_NUMBER;
          end else if (is_alp) begin
            mode_a  = MODE_WORD;
            wbuf_a  = KCB'(symbol);
            wlen_a  = WLW'(1);
            wlong_a = 1'b0;
          end else begin
            cand[1] = mk(kls_pkg::KIND_NONE, kls_pkg::ERR_CHAR, symbol, pos_r, 16'd1, line_r);
            cv[1]   = 1'b1;
          end
        end
      endcase
    end

    // End of source: flush what is open, then end of file
    if (final_req) begin
      case (mode_a)
        MODE_STRING: begin
          cand[2] = mk(kls_pkg::KIND_STRING, kls_pkg::ERR_UNTERM, 8'd0,
                       cap16({1'b0, ts_a} + 17'd1),
                       span(end1, {1'b0, ts_a} + 17'd1), line_a);
          cv[2]   = 1'b1;
        end
        MODE_NUMBER: begin
          cand[2] = mk(kls_pkg::KIND_NUMBER, kls_pkg::ERR_NONE, 8'd0, ts_a,
                       span(end1, {1'b0, ts_a}), line_a);
          cv[2]   = 1'b1;
        end
        MODE_WORD: begin
          cand[2] = mk(word_kind(wbuf_a, wlen_a, wlong_a), kls_pkg::ERR_NONE, 8'd0, ts_a,
                       span(end1, {1'b0, ts_a}), line_a);
          cv[2]   = 1'b1;
        end
        default: begin
        end
      endcase
      cand[3] = mk(kls_pkg::KIND_EOF, kls_pkg::ERR_NONE, 8'd0, cap16(end1), 16'd0, line_a);
      cv[3]   = 1'b1;
    end
  end

  // Pack the valid results in order and mark the final one
  always_comb begin
    res_set = '0;
    n       = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && n < 3'd3) begin
        res_set.item[n[1:0]] = cand[i];
        n                    = n + 3'd1;
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (3'(j) + 3'd1 == n) begin
        res_set.item[j].last = 1'b1;
      end
    end
    res_set.cnt = n[1:0];
  end

  // Next state
  always_comb begin
    if (final_req) begin
      mode_nxt  = MODE_IDLE;
      pos_nxt   = 16'd0;
      ts_nxt    = 16'd0;
      line_nxt  = 16'd1;
      wbuf_nxt  = '0;
      wlen_nxt  = '0;
      wlong_nxt = 1'b0;
    end else begin
      mode_nxt  = mode_a;
      pos_nxt   = (pos_r < POS_MAX) ? (pos_r + 16'd1) : pos_r;
      ts_nxt    = ts_a;
      line_nxt  = line_a;
      wbuf_nxt  = wbuf_a;
      wlen_nxt  = wlen_a;
      wlong_nxt = wlong_a;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= 16'd0;
      ts_r    <= 16'd0;
      line_r  <= 16'd1;
      wbuf_r  <= '0;
      wlen_r  <= '0;
      wlong_r <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      ts_r    <= ts_nxt;
      line_r  <= line_nxt;
      wbuf_r  <= wbuf_nxt;
      wlen_r  <= wlen_nxt;
      wlong_r <= wlong_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kls_rbuf.sv =====
// Result buffer of the keyword lexer: holds the up to three results of one byte
// and hands them out one transfer at a time. Depends on kls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kls_rbuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire kls_pkg::res_set_t res_set,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output kls_pkg::res_t          out_item
);

  kls_pkg::res_t slot_r [3];
  logic [1:0]    rem_r;
  logic [1:0]    idx_r;
  logic          drain;

  // Output side and room for the next byte's results
  assign out_valid = (rem_r != 2'd0);
  assign out_item  = slot_r[idx_r];
  assign drain     = out_valid && out_ready;
  assign free      = (rem_r == 2'd0) || (rem_r == 2'd1 && out_ready);

  // Count of results still to go and the read pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      rem_r <= res_set.cnt;
      idx_r <= 2'd0;
    end else if (drain) begin
      rem_r <= rem_r - 2'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  // Result slots
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        slot_r[i] <= res_set.item[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/keyword_lexer_stream_unit.sv =====
// Top level of the keyword lexer: input register, scanner and result buffer.
// Depends on kls_pkg, kls_scan and kls_rbuf.
//
// Source bytes enter one transfer per cycle on the in_ stream while in_tready is
// high, the last byte of a source flagged by in_tlast; tokens leave on the out_
// stream, one per transfer, with out_tlast on the final result caused by each
// byte. A byte is registered, scanned once the result buffer has room, and its
// results (none to three) are written to the result buffer in the same step. The
// single output port drains that buffer one result per cycle while out_tready is
// high; a byte yields at most three results: a token that the byte closes, the
// byte's own token, and at end of source a flushed token plus end of file.
// Positions, lengths and line numbers saturate at 65535; after the end-of-file
// result the scanner is back in its reset state for the next source.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer_stream_unit #(
  parameter longint unsigned SOURCE_LIMIT  = 65536,
  parameter int              KEYWORD_CHARS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic        in_tlast,   // final_req
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // kind, error, bad_char, offset, length, line_no, 0
  output logic             out_tlast   // last
);

  logic              in_vld_r;
  logic [7:0]        in_sym_r;
  logic              in_fin_r;
  logic              consume;
  logic              buf_free;
  kls_pkg::res_set_t res_set;
  kls_pkg::res_t     out_item;

  // Input register: refilled whenever the held byte is scanned or the slot is empty
  assign consume   = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_sym_r <= in_tdata;
      in_fin_r <= in_tlast;
    end
  end

  kls_scan #(
    .SOURCE_LIMIT  (SOURCE_LIMIT),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (consume),
    .symbol    (in_sym_r),
    .final_req (in_fin_r),
    .res_set   (res_set)
  );

  kls_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (consume),
    .res_set   (res_set),
    .free      (buf_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  // Result packing, first field in the lowest bits
  assign out_tdata = {1'b0, out_item.line_no, out_item.length, out_item.offset,
                      out_item.bad_char, out_item.error, out_item.kind};
  assign out_tlast = out_item.last;

endmodule

`default_nettype wire

// ===== sv/kls_checker.sv =====
// Port-level checks for the keyword lexer, bound to the top level.
// Depends on keyword_lexer_stream_unit and kls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kls_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tlast
);

  logic [4:0]  kind;
  logic [1:0]  error;
  logic [15:0] length;
  logic [15:0] line_no;

  assign kind    = out_tdata[4:0];
  assign error   = out_tdata[6:5];
  assign length  = out_tdata[46:31];
  assign line_no = out_tdata[62:47];

  // A stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // End of file always closes the byte's results and has no text
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && kind == kls_pkg::KIND_EOF |-> out_tlast && length == 16'd0)
    else $error("end of file not last or not empty");

  // An unexpected character is one byte long and has no kind
  a_bad_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && error == kls_pkg::ERR_CHAR |-> length == 16'd1 && kind == kls_pkg::KIND_NONE)
    else $error("unexpected character result malformed");

  // Line numbers start at one and never wrap to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> line_no != 16'd0)
    else $error("line number zero");

endmodule

bind keyword_lexer_stream_unit kls_checker u_kls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
